>>> hdl/stme_pkg.sv
// ============================================================================
// Spinor transition matrix element: shared types and constants
// Holds the datapath widths, the register map and the microcode of the
// shared multiply-accumulate sequencer.
// ============================================================================
package stme_pkg;

   localparam int FIELD_W   = 16;
   localparam int MUL_A_W   = 35;
   localparam int MUL_B_W   = 19;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int ACC_W     = 58;
   localparam int GE_W      = 34;
   localparam int QE_W      = 35;
   localparam int SP_W      = 19;
   localparam int H_W       = 46;
   localparam int HSUM_W    = H_W + 1;
   localparam int SUM_W     = 48;
   localparam int TOT_W     = SUM_W + 1;
   localparam int STEP_W    = 7;
   localparam int UCODE_LEN = 66;
   localparam int CSR_AW    = 5;
   localparam int CSR_DW    = 32;

   localparam logic [CSR_DW-1:0] POL_X_RESET = 32'h4000_0000;

   localparam logic [2:0] REG_POL_X = 3'd0;
   localparam logic [2:0] REG_POL_Y = 3'd1;
   localparam logic [2:0] REG_POL_Z = 3'd2;
   localparam logic [2:0] REG_Q_X   = 3'd3;
   localparam logic [2:0] REG_Q_Y   = 3'd4;
   localparam logic [2:0] REG_Q_Z   = 3'd5;

   typedef enum logic [4:0] {
      A_GX, A_GY, A_GZ, A_QX, A_QY, A_QZ,
      A_AUR, A_AUI, A_ADR, A_ADI, A_GER, A_GEI,
      A_QE0R, A_QE0I, A_QE1R, A_QE1I, A_QE2R, A_QE2I
   } asel_type;

   typedef enum logic [4:0] {
      B_EXR, B_EXI, B_EYR, B_EYI, B_EZR, B_EZI,
      B_BUR, B_BUI, B_BDR, B_BDI, B_S0R, B_S0I,
      B_SG0R, B_SG0I, B_SG1R, B_SG1I, B_SG2R, B_SG2I
   } bsel_type;

   typedef enum logic [4:0] {
      D_GER, D_GEI, D_QE0R, D_QE0I, D_QE1R, D_QE1I, D_QE2R, D_QE2I,
      D_S0R, D_S0I, D_SG0R, D_SG0I, D_SG1R, D_SG1I, D_SG2R, D_SG2I,
      D_H1R, D_H1I, D_H2R, D_H2I
   } dest_type;

   typedef struct packed {
      asel_type a_sel;
      bsel_type b_sel;
      logic     neg;
      logic     first;
      logic     last;
      dest_type dest;
   } ucode_type;

   function automatic logic [3:0] dest_shift(input dest_type d);
      logic [3:0] s;
      case (d)
         D_GER, D_GEI: s = 4'd0;
         D_QE0R, D_QE0I, D_QE1R, D_QE1I, D_QE2R, D_QE2I: s = 4'd14;
         D_H1R, D_H1I: s = 4'd8;
         default: s = 4'd15;
      endcase
      return s;
   endfunction

   function automatic ucode_type mk(input asel_type a, input bsel_type b, input logic neg,
                                    input logic first, input logic last, input dest_type d);
      ucode_type u;
      u.a_sel = a;
      u.b_sel = b;
      u.neg   = neg;
      u.first = first;
      u.last  = last;
      u.dest  = d;
      return u;
   endfunction

   function automatic ucode_type ucode(input logic [STEP_W-1:0] step);
      ucode_type u;
      case (step)
         7'd0:  u = mk(A_GX,   B_EXR,  1'b0, 1'b1, 1'b0, D_GER);
         7'd1:  u = mk(A_GY,   B_EYR,  1'b0, 1'b0, 1'b0, D_GER);
         7'd2:  u = mk(A_GZ,   B_EZR,  1'b0, 1'b0, 1'b1, D_GER);
         7'd3:  u = mk(A_GX,   B_EXI,  1'b0, 1'b1, 1'b0, D_GEI);
         7'd4:  u = mk(A_GY,   B_EYI,  1'b0, 1'b0, 1'b0, D_GEI);
         7'd5:  u = mk(A_GZ,   B_EZI,  1'b0, 1'b0, 1'b1, D_GEI);
         7'd6:  u = mk(A_QY,   B_EZR,  1'b0, 1'b1, 1'b0, D_QE0R);
         7'd7:  u = mk(A_QZ,   B_EYR,  1'b1, 1'b0, 1'b1, D_QE0R);
         7'd8:  u = mk(A_QY,   B_EZI,  1'b0, 1'b1, 1'b0, D_QE0I);
         7'd9:  u = mk(A_QZ,   B_EYI,  1'b1, 1'b0, 1'b1, D_QE0I);
         7'd10: u = mk(A_QZ,   B_EXR,  1'b0, 1'b1, 1'b0, D_QE1R);
         7'd11: u = mk(A_QX,   B_EZR,  1'b1, 1'b0, 1'b1, D_QE1R);
         7'd12: u = mk(A_QZ,   B_EXI,  1'b0, 1'b1, 1'b0, D_QE1I);
         7'd13: u = mk(A_QX,   B_EZI,  1'b1, 1'b0, 1'b1, D_QE1I);
         7'd14: u = mk(A_QX,   B_EYR,  1'b0, 1'b1, 1'b0, D_QE2R);
         7'd15: u = mk(A_QY,   B_EXR,  1'b1, 1'b0, 1'b1, D_QE2R);
         7'd16: u = mk(A_QX,   B_EYI,  1'b0, 1'b1, 1'b0, D_QE2I);
         7'd17: u = mk(A_QY,   B_EXI,  1'b1, 1'b0, 1'b1, D_QE2I);
         7'd18: u = mk(A_AUR,  B_BUR,  1'b0, 1'b1, 1'b0, D_S0R);
         7'd19: u = mk(A_AUI,  B_BUI,  1'b0, 1'b0, 1'b0, D_S0R);
         7'd20: u = mk(A_ADR,  B_BDR,  1'b0, 1'b0, 1'b0, D_S0R);
         7'd21: u = mk(A_ADI,  B_BDI,  1'b0, 1'b0, 1'b1, D_S0R);
         7'd22: u = mk(A_AUR,  B_BUI,  1'b0, 1'b1, 1'b0, D_S0I);
         7'd23: u = mk(A_AUI,  B_BUR,  1'b1, 1'b0, 1'b0, D_S0I);
         7'd24: u = mk(A_ADR,  B_BDI,  1'b0, 1'b0, 1'b0, D_S0I);
         7'd25: u = mk(A_ADI,  B_BDR,  1'b1, 1'b0, 1'b1, D_S0I);
         7'd26: u = mk(A_AUR,  B_BDR,  1'b0, 1'b1, 1'b0, D_SG0R);
         7'd27: u = mk(A_AUI,  B_BDI,  1'b0, 1'b0, 1'b0, D_SG0R);
         7'd28: u = mk(A_ADR,  B_BUR,  1'b0, 1'b0, 1'b0, D_SG0R);
         7'd29: u = mk(A_ADI,  B_BUI,  1'b0, 1'b0, 1'b1, D_SG0R);
         7'd30: u = mk(A_AUR,  B_BDI,  1'b0, 1'b1, 1'b0, D_SG0I);
         7'd31: u = mk(A_AUI,  B_BDR,  1'b1, 1'b0, 1'b0, D_SG0I);
         7'd32: u = mk(A_ADR,  B_BUI,  1'b0, 1'b0, 1'b0, D_SG0I);
         7'd33: u = mk(A_ADI,  B_BUR,  1'b1, 1'b0, 1'b1, D_SG0I);
         7'd34: u = mk(A_AUR,  B_BDI,  1'b0, 1'b1, 1'b0, D_SG1R);
         7'd35: u = mk(A_AUI,  B_BDR,  1'b1, 1'b0, 1'b0, D_SG1R);
         7'd36: u = mk(A_ADR,  B_BUI,  1'b1, 1'b0, 1'b0, D_SG1R);
         7'd37: u = mk(A_ADI,  B_BUR,  1'b0, 1'b0, 1'b1, D_SG1R);
         7'd38: u = mk(A_ADR,  B_BUR,  1'b0, 1'b1, 1'b0, D_SG1I);
         7'd39: u = mk(A_ADI,  B_BUI,  1'b0, 1'b0, 1'b0, D_SG1I);
         7'd40: u = mk(A_AUR,  B_BDR,  1'b1, 1'b0, 1'b0, D_SG1I);
         7'd41: u = mk(A_AUI,  B_BDI,  1'b1, 1'b0, 1'b1, D_SG1I);
         7'd42: u = mk(A_AUR,  B_BUR,  1'b0, 1'b1, 1'b0, D_SG2R);
         7'd43: u = mk(A_AUI,  B_BUI,  1'b0, 1'b0, 1'b0, D_SG2R);
         7'd44: u = mk(A_ADR,  B_BDR,  1'b1, 1'b0, 1'b0, D_SG2R);
         7'd45: u = mk(A_ADI,  B_BDI,  1'b1, 1'b0, 1'b1, D_SG2R);
         7'd46: u = mk(A_AUR,  B_BUI,  1'b0, 1'b1, 1'b0, D_SG2I);
         7'd47: u = mk(A_AUI,  B_BUR,  1'b1, 1'b0, 1'b0, D_SG2I);
         7'd48: u = mk(A_ADR,  B_BDI,  1'b1, 1'b0, 1'b0, D_SG2I);
         7'd49: u = mk(A_ADI,  B_BDR,  1'b0, 1'b0, 1'b1, D_SG2I);
         7'd50: u = mk(A_GER,  B_S0R,  1'b0, 1'b1, 1'b0, D_H1R);
         7'd51: u = mk(A_GEI,  B_S0I,  1'b1, 1'b0, 1'b1, D_H1R);
         7'd52: u = mk(A_GER,  B_S0I,  1'b0, 1'b1, 1'b0, D_H1I);
         7'd53: u = mk(A_GEI,  B_S0R,  1'b0, 1'b0, 1'b1, D_H1I);
         7'd54: u = mk(A_QE0R, B_SG0I, 1'b1, 1'b1, 1'b0, D_H2R);
         7'd55: u = mk(A_QE0I, B_SG0R, 1'b1, 1'b0, 1'b0, D_H2R);
         7'd56: u = mk(A_QE1R, B_SG1I, 1'b1, 1'b0, 1'b0, D_H2R);
         7'd57: u = mk(A_QE1I, B_SG1R, 1'b1, 1'b0, 1'b0, D_H2R);
         7'd58: u = mk(A_QE2R, B_SG2I, 1'b1, 1'b0, 1'b0, D_H2R);
         7'd59: u = mk(A_QE2I, B_SG2R, 1'b1, 1'b0, 1'b1, D_H2R);
         7'd60: u = mk(A_QE0R, B_SG0R, 1'b0, 1'b1, 1'b0, D_H2I);
         7'd61: u = mk(A_QE0I, B_SG0I, 1'b1, 1'b0, 1'b0, D_H2I);
         7'd62: u = mk(A_QE1R, B_SG1R, 1'b0, 1'b0, 1'b0, D_H2I);
         7'd63: u = mk(A_QE1I, B_SG1I, 1'b1, 1'b0, 1'b0, D_H2I);
         7'd64: u = mk(A_QE2R, B_SG2R, 1'b0, 1'b0, 1'b0, D_H2I);
         7'd65: u = mk(A_QE2I, B_SG2I, 1'b1, 1'b0, 1'b1, D_H2I);
         default: u = mk(A_GX, B_EXR, 1'b0, 1'b1, 1'b0, D_H2I);
      endcase
      return u;
   endfunction

endpackage

>>> hdl/spinor_transition_matrix_element.sv
// ============================================================================
// Spinor transition matrix element accumulator
// Sums 2(g.e)s0 + i(q x e).sigma over a run of plane-wave coefficients and
// delivers the saturated complex sum on the transfer marked last.
// ============================================================================
// A new input transfer is accepted only once the previous item is through:
// a single shared 35 x 19 bit multiplier with a 58-bit accumulator works
// through 66 products per item (the g.e and q x e terms, s0 and sigma, then
// the two output terms), followed by states that drain the multiplier pipeline,
// combine the terms and update the saturating 48-bit sum. req_tready is high only between items.
// A result is held in an output register until taken; the next item can be
// accepted meanwhile, but a later last-marked item waits for that register.
module spinor_transition_matrix_element
   import stme_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // g_x, g_y, g_z, init_up_re, init_up_im, init_dn_re, init_dn_im,
   // final_up_re, final_up_im, final_dn_re, final_dn_im (16 bits each)
   input  logic [175:0]        req_tdata,
   input  logic                req_tlast,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // sum_re, sum_im (48 bits each)
   output logic [95:0]         rsp_tdata,
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [CSR_AW-1:0]   csr_paddr,
   input  logic [CSR_DW-1:0]   csr_pwdata,
   output logic [CSR_DW-1:0]   csr_prdata,
   output logic                csr_pready
);

   typedef enum logic [2:0] {S_IDLE, S_RUN, S_DRAIN, S_SUM, S_SAT} state_type;

   localparam logic signed [TOT_W-1:0] TOT_MAX = {2'b00, {(SUM_W-1){1'b1}}};
   localparam logic signed [TOT_W-1:0] TOT_MIN = {2'b11, {(SUM_W-1){1'b0}}};

   state_type                  state_ff, state_in;
   logic [STEP_W-1:0]          step_ff;
   logic                       mvld_ff;
   ucode_type                  ctl_ff, ctl_in;
   logic                       last_ff;
   logic                       rsp_tvalid_ff;
   logic signed [SUM_W-1:0]    acc_re_ff, acc_im_ff;
   logic signed [SUM_W-1:0]    rsp_re_ff, rsp_im_ff;

   logic [CSR_DW-1:0]          pol_x_ff, pol_y_ff, pol_z_ff;
   logic [CSR_DW-1:0]          q_x_ff, q_y_ff, q_z_ff;

   logic signed [FIELD_W-1:0]  g_x_ff, g_y_ff, g_z_ff;
   logic signed [FIELD_W-1:0]  au_re_ff, au_im_ff, ad_re_ff, ad_im_ff;
   logic signed [FIELD_W-1:0]  bu_re_ff, bu_im_ff, bd_re_ff, bd_im_ff;

   logic signed [GE_W-1:0]     ge_re_ff, ge_im_ff;
   logic signed [QE_W-1:0]     qe0_re_ff, qe0_im_ff, qe1_re_ff, qe1_im_ff;
   logic signed [QE_W-1:0]     qe2_re_ff, qe2_im_ff;
   logic signed [SP_W-1:0]     s0_re_ff, s0_im_ff, sg0_re_ff, sg0_im_ff;
   logic signed [SP_W-1:0]     sg1_re_ff, sg1_im_ff, sg2_re_ff, sg2_im_ff;
   logic signed [H_W-1:0]      h1_re_ff, h1_im_ff, h2_re_ff, h2_im_ff;
   logic signed [HSUM_W-1:0]   hsum_re_ff, hsum_im_ff;

   logic signed [FIELD_W-1:0]  ex_re, ex_im, ey_re, ey_im, ez_re, ez_im;
   logic signed [MUL_A_W-1:0]  a_op;
   logic signed [MUL_B_W-1:0]  b_op;
   logic signed [PROD_W-1:0]   prod_ff;
   logic signed [ACC_W-1:0]    mac_ff, mac_in, prod_ext, addend, bias, base;
   logic signed [ACC_W-1:0]    shifted;
   logic [3:0]                 shamt;
   logic                       store;
   logic signed [TOT_W-1:0]    tot_re, tot_im;
   logic signed [SUM_W-1:0]    sat_re, sat_im;
   logic                       req_accept, csr_write, out_busy;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_im_ff, rsp_re_ff};
   assign out_busy   = rsp_tvalid_ff && !rsp_tready;

   assign ex_re = pol_x_ff[31:16];
   assign ex_im = pol_x_ff[15:0];
   assign ey_re = pol_y_ff[31:16];
   assign ey_im = pol_y_ff[15:0];
   assign ez_re = pol_z_ff[31:16];
   assign ez_im = pol_z_ff[15:0];

   always_comb begin
      case (csr_paddr[4:2])
         REG_POL_X: csr_prdata = pol_x_ff;
         REG_POL_Y: csr_prdata = pol_y_ff;
         REG_POL_Z: csr_prdata = pol_z_ff;
         REG_Q_X:   csr_prdata = q_x_ff;
         REG_Q_Y:   csr_prdata = q_y_ff;
         REG_Q_Z:   csr_prdata = q_z_ff;
         default:   csr_prdata = '0;
      endcase
   end

   assign ctl_in = ucode(step_ff);

   always_comb begin
      case (ctl_in.a_sel)
         A_GX:    a_op = MUL_A_W'(g_x_ff);
         A_GY:    a_op = MUL_A_W'(g_y_ff);
         A_GZ:    a_op = MUL_A_W'(g_z_ff);
         A_QX:    a_op = MUL_A_W'(signed'(q_x_ff));
         A_QY:    a_op = MUL_A_W'(signed'(q_y_ff));
         A_QZ:    a_op = MUL_A_W'(signed'(q_z_ff));
         A_AUR:   a_op = MUL_A_W'(au_re_ff);
         A_AUI:   a_op = MUL_A_W'(au_im_ff);
         A_ADR:   a_op = MUL_A_W'(ad_re_ff);
         A_ADI:   a_op = MUL_A_W'(ad_im_ff);
         A_GER:   a_op = MUL_A_W'(ge_re_ff);
         A_GEI:   a_op = MUL_A_W'(ge_im_ff);
         A_QE0R:  a_op = qe0_re_ff;
         A_QE0I:  a_op = qe0_im_ff;
         A_QE1R:  a_op = qe1_re_ff;
         A_QE1I:  a_op = qe1_im_ff;
         A_QE2R:  a_op = qe2_re_ff;
         A_QE2I:  a_op = qe2_im_ff;
         default: a_op = '0;
      endcase
   end

   always_comb begin
      case (ctl_in.b_sel)
         B_EXR:   b_op = MUL_B_W'(ex_re);
         B_EXI:   b_op = MUL_B_W'(ex_im);
         B_EYR:   b_op = MUL_B_W'(ey_re);
         B_EYI:   b_op = MUL_B_W'(ey_im);
         B_EZR:   b_op = MUL_B_W'(ez_re);
         B_EZI:   b_op = MUL_B_W'(ez_im);
         B_BUR:   b_op = MUL_B_W'(bu_re_ff);
         B_BUI:   b_op = MUL_B_W'(bu_im_ff);
         B_BDR:   b_op = MUL_B_W'(bd_re_ff);
         B_BDI:   b_op = MUL_B_W'(bd_im_ff);
         B_S0R:   b_op = s0_re_ff;
         B_S0I:   b_op = s0_im_ff;
         B_SG0R:  b_op = sg0_re_ff;
         B_SG0I:  b_op = sg0_im_ff;
         B_SG1R:  b_op = sg1_re_ff;
         B_SG1I:  b_op = sg1_im_ff;
         B_SG2R:  b_op = sg2_re_ff;
         B_SG2I:  b_op = sg2_im_ff;
         default: b_op = '0;
      endcase
   end

   // Rounding is folded into the accumulator: the first product of a group
   // starts from the half-LSB bias, so the stored value is a plain shift.
   assign shamt    = dest_shift(ctl_ff.dest);
   assign bias     = (shamt == 4'd0) ? '0 : (ACC_W'(1) << (shamt - 4'd1));
   assign prod_ext = ACC_W'(prod_ff);
   assign addend   = ctl_ff.neg ? -prod_ext : prod_ext;
   assign base     = ctl_ff.first ? bias : mac_ff;
   assign mac_in   = base + addend;
   assign shifted  = mac_in >>> shamt;
   assign store    = mvld_ff && ctl_ff.last;

   assign tot_re = TOT_W'(acc_re_ff) + TOT_W'(hsum_re_ff);
   assign tot_im = TOT_W'(acc_im_ff) + TOT_W'(hsum_im_ff);

   always_comb begin
      if (tot_re > TOT_MAX) begin
         sat_re = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (tot_re < TOT_MIN) begin
         sat_re = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sat_re = SUM_W'(tot_re);
      end
      if (tot_im > TOT_MAX) begin
         sat_im = {1'b0, {(SUM_W-1){1'b1}}};
      end else if (tot_im < TOT_MIN) begin
         sat_im = {1'b1, {(SUM_W-1){1'b0}}};
      end else begin
         sat_im = SUM_W'(tot_im);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (req_accept) state_in = S_RUN;
         S_RUN:   if (step_ff == STEP_W'(UCODE_LEN - 1)) state_in = S_DRAIN;
         S_DRAIN: state_in = S_SUM;
         S_SUM:   state_in = S_SAT;
         S_SAT:   if (!(last_ff && out_busy)) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         mvld_ff       <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         acc_re_ff     <= '0;
         acc_im_ff     <= '0;
         pol_x_ff      <= POL_X_RESET;
         pol_y_ff      <= '0;
         pol_z_ff      <= '0;
         q_x_ff        <= '0;
         q_y_ff        <= '0;
         q_z_ff        <= '0;
      end else begin
         state_ff <= state_in;
         mvld_ff  <= (state_ff == S_RUN);
         if (state_ff == S_RUN) begin
            step_ff <= step_ff + STEP_W'(1);
         end else begin
            step_ff <= '0;
         end
         if (csr_write) begin
            case (csr_paddr[4:2])
               REG_POL_X: pol_x_ff <= csr_pwdata;
               REG_POL_Y: pol_y_ff <= csr_pwdata;
               REG_POL_Z: pol_z_ff <= csr_pwdata;
               REG_Q_X:   q_x_ff   <= csr_pwdata;
               REG_Q_Y:   q_y_ff   <= csr_pwdata;
               REG_Q_Z:   q_z_ff   <= csr_pwdata;
               default:   ;
            endcase
         end
         if (state_ff == S_SAT && last_ff && !out_busy) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tvalid_ff && rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
         if (state_ff == S_SAT && !(last_ff && out_busy)) begin
            if (last_ff) begin
               acc_re_ff <= '0;
               acc_im_ff <= '0;
            end else begin
               acc_re_ff <= sat_re;
               acc_im_ff <= sat_im;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         g_x_ff   <= req_tdata[15:0];
         g_y_ff   <= req_tdata[31:16];
         g_z_ff   <= req_tdata[47:32];
         au_re_ff <= req_tdata[63:48];
         au_im_ff <= req_tdata[79:64];
         ad_re_ff <= req_tdata[95:80];
         ad_im_ff <= req_tdata[111:96];
         bu_re_ff <= req_tdata[127:112];
         bu_im_ff <= req_tdata[143:128];
         bd_re_ff <= req_tdata[159:144];
         bd_im_ff <= req_tdata[175:160];
         last_ff  <= req_tlast;
      end
      prod_ff <= a_op * b_op;
      ctl_ff  <= ctl_in;
      if (mvld_ff) begin
         mac_ff <= mac_in;
      end
      if (store) begin
         case (ctl_ff.dest)
            D_GER:   ge_re_ff  <= GE_W'(shifted);
            D_GEI:   ge_im_ff  <= GE_W'(shifted);
            D_QE0R:  qe0_re_ff <= QE_W'(shifted);
            D_QE0I:  qe0_im_ff <= QE_W'(shifted);
            D_QE1R:  qe1_re_ff <= QE_W'(shifted);
            D_QE1I:  qe1_im_ff <= QE_W'(shifted);
            D_QE2R:  qe2_re_ff <= QE_W'(shifted);
            D_QE2I:  qe2_im_ff <= QE_W'(shifted);
            D_S0R:   s0_re_ff  <= SP_W'(shifted);
            D_S0I:   s0_im_ff  <= SP_W'(shifted);
            D_SG0R:  sg0_re_ff <= SP_W'(shifted);
            D_SG0I:  sg0_im_ff <= SP_W'(shifted);
            D_SG1R:  sg1_re_ff <= SP_W'(shifted);
            D_SG1I:  sg1_im_ff <= SP_W'(shifted);
            D_SG2R:  sg2_re_ff <= SP_W'(shifted);
            D_SG2I:  sg2_im_ff <= SP_W'(shifted);
            D_H1R:   h1_re_ff  <= H_W'(shifted);
            D_H1I:   h1_im_ff  <= H_W'(shifted);
            D_H2R:   h2_re_ff  <= H_W'(shifted);
            D_H2I:   h2_im_ff  <= H_W'(shifted);
            default: ;
         endcase
      end
      if (state_ff == S_SUM) begin
         hsum_re_ff <= HSUM_W'(h1_re_ff) + HSUM_W'(h2_re_ff);
         hsum_im_ff <= HSUM_W'(h1_im_ff) + HSUM_W'(h2_im_ff);
      end
      if (state_ff == S_SAT && last_ff && !out_busy) begin
         rsp_re_ff <= sat_re;
         rsp_im_ff <= sat_im;
      end
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted again while an item is in progress");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> step_ff < STEP_W'(UCODE_LEN))
      else $error("microcode step beyond the program");

   a_clear_on_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SAT && state_in == S_IDLE && last_ff)
         |=> (acc_re_ff == '0 && acc_im_ff == '0 && rsp_tvalid_ff))
      else $error("sum not emitted and cleared on a last transfer");

   a_store_in_pipe: assert property (@(posedge clock) disable iff (reset)
      mvld_ff |-> (state_ff == S_RUN || state_ff == S_DRAIN))
      else $error("multiplier result outside the run");

endmodule

>>> test/spinor_transition_matrix_element_tb.sv
// ============================================================================
// Spinor transition matrix element accumulator testbench
// Streams plane-wave coefficient transfers through the block under several
// polarization and photon settings, predicts each saturated complex sum and
// compares every result transfer against the predicted sums in order.
// ============================================================================
`timescale 1ns / 100ps

class stme_scoreboard;
   logic [47:0] sums_re[$];
   logic [47:0] sums_im[$];
   int          errors;
   int          reported;
   logic signed [31:0] polr[3];
   logic signed [31:0] poli[3];
   logic signed [31:0] qv[3];
   logic signed [63:0] acc_re;
   logic signed [63:0] acc_im;

   function new();
      errors = 0;
      reported = 0;
      acc_re = 0;
      acc_im = 0;
      polr[0] = 16384;
      poli[0] = 0;
      for (int i = 1; i < 3; i++) begin
         polr[i] = 0;
         poli[i] = 0;
      end
      for (int i = 0; i < 3; i++) qv[i] = 0;
   endfunction

   function void set_reg(int idx, logic [31:0] v);
      if (idx < 3) begin
         polr[idx] = $signed(v[31:16]);
         poli[idx] = $signed(v[15:0]);
      end else if (idx < 6) begin
         qv[idx-3] = $signed(v);
      end
   endfunction

   function logic signed [63:0] rnd(logic signed [63:0] x, int n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function logic signed [63:0] sat48(logic signed [63:0] x);
      if (x > 64'sh7FFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF;
      if (x < -64'sh8000_0000_0000) return -64'sh8000_0000_0000;
      return x;
   endfunction

   function void note_input(logic [175:0] d, logic last);
      logic signed [63:0] f[11];
      logic signed [63:0] qer[3], qei[3], sr[3], si[3];
      logic signed [63:0] ppr, ppi, pqr, pqi, prr, pri, psr, psi;
      logic signed [63:0] s0r, s0i, ger, gei, h1r, h1i, tr, ti;
      int j, k;
      for (int i = 0; i < 11; i++) f[i] = $signed(d[16*i +: 16]);
      for (int i = 0; i < 3; i++) begin
         j = (i + 1) % 3;
         k = (i + 2) % 3;
         qer[i] = rnd(qv[j] * polr[k] - qv[k] * polr[j], 14);
         qei[i] = rnd(qv[j] * poli[k] - qv[k] * poli[j], 14);
      end
      ppr = f[3] * f[7] + f[4] * f[8];
      ppi = f[3] * f[8] - f[4] * f[7];
      pqr = f[3] * f[9] + f[4] * f[10];
      pqi = f[3] * f[10] - f[4] * f[9];
      prr = f[5] * f[7] + f[6] * f[8];
      pri = f[5] * f[8] - f[6] * f[7];
      psr = f[5] * f[9] + f[6] * f[10];
      psi = f[5] * f[10] - f[6] * f[9];
      s0r = rnd(ppr + psr, 15);
      s0i = rnd(ppi + psi, 15);
      sr[0] = rnd(pqr + prr, 15);
      si[0] = rnd(pqi + pri, 15);
      sr[1] = rnd(pqi - pri, 15);
      si[1] = rnd(prr - pqr, 15);
      sr[2] = rnd(ppr - psr, 15);
      si[2] = rnd(ppi - psi, 15);
      ger = 0;
      gei = 0;
      tr = 0;
      ti = 0;
      for (int i = 0; i < 3; i++) begin
         ger += f[i] * polr[i];
         gei += f[i] * poli[i];
         tr += qer[i] * sr[i] - qei[i] * si[i];
         ti += qer[i] * si[i] + qei[i] * sr[i];
      end
      h1r = rnd(ger * s0r - gei * s0i, 8);
      h1i = rnd(ger * s0i + gei * s0r, 8);
      acc_re = sat48(acc_re + h1r + rnd(-ti, 15));
      acc_im = sat48(acc_im + h1i + rnd(tr, 15));
      if (last) begin
         sums_re.push_back(acc_re[47:0]);
         sums_im.push_back(acc_im[47:0]);
         acc_re = 0;
         acc_im = 0;
      end
   endfunction

   function void check_result(logic [95:0] d);
      logic [47:0] er, ei;
      if (sums_re.size() == 0) begin
         errors++;
         if (reported < 10) begin
            reported++;
            $display("unexpected result transfer %h", d);
         end
         return;
      end
      er = sums_re.pop_front();
      ei = sums_im.pop_front();
      if (er !== d[47:0] || ei !== d[95:48]) begin
         errors++;
         if (reported < 10) begin
            reported++;
            $display("sum mismatch: expected re %h im %h, got re %h im %h",
                     er, ei, d[47:0], d[95:48]);
         end
      end
   endfunction
endclass

module spinor_transition_matrix_element_tb;
   import stme_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [175:0]       req_tdata = '0;
   logic               req_tlast = 1'b0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [95:0]        rsp_tdata;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]  csr_paddr = '0;
   logic [CSR_DW-1:0]  csr_pwdata = '0;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   stme_scoreboard sb = new();
   int cycles = 0;
   int burst_left = 0;

   spinor_transition_matrix_element u_top (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      if (reset) rsp_tready <= 1'b0;
      else if ((cycles / 300) % 3 == 0) rsp_tready <= 1'b1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'(idx) << 2;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(idx, v);
   endtask

   task automatic send_item(input logic [175:0] d, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 40);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_input(d, last);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.sums_re.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [175:0] rand_data(int mode);
      logic [175:0] d;
      for (int i = 0; i < 11; i++) begin
         case (mode)
            0: d[16*i +: 16] = 16'h7FFF;
            1: d[16*i +: 16] = 16'h8000;
            default: d[16*i +: 16] = 16'($urandom);
         endcase
      end
      return d;
   endfunction

   task automatic configure(input int mode);
      logic [31:0] v;
      for (int i = 0; i < 6; i++) begin
         case (mode)
            0: v = (i < 3) ? 32'h7FFF_7FFF : 32'h7FFF_FFFF;
            1: v = (i < 3) ? 32'h8000_8000 : 32'h8000_0000;
            2: v = (i < 3) ? 32'h7FFF_8000 : 32'h8000_0000;
            default: v = $urandom;
         endcase
         write_reg(3'(i), v);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_item(rand_data(2), 1'b0);
      send_item(rand_data(0), 1'b1);
      drain();
      configure(0);
      for (int i = 0; i < 8; i++) send_item(rand_data(i % 2), i == 7);
      send_item(rand_data(0), 1'b1);
      drain();
      configure(1);
      for (int i = 0; i < 8; i++) send_item(rand_data(i % 2), i == 7);
      send_item(rand_data(1), 1'b1);
      drain();
      configure(2);
      for (int i = 0; i < 4; i++) send_item(rand_data(2), 1'b1);
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         configure(ph == 5 ? 2 : 3);
         for (int i = 0; i < 200; i++)
            send_item(rand_data($urandom_range(0, 15) == 0 ? $urandom_range(0, 1) : 2),
                      (i == 199) || ($urandom_range(0, 5) == 0));
         drain();
      end
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

>>> filelist.f
hdl/stme_pkg.sv
hdl/spinor_transition_matrix_element.sv
test/spinor_transition_matrix_element_tb.sv
